FILE: rtl/bmf_pkg.sv
`default_nettype none

package bmf_pkg;

  localparam int NUM_QUEUES_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int DATA_W          = 32;

  typedef logic [1:0] qnum_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_DELETE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/bmf_select.sv
`default_nettype none

module bmf_select #(
  parameter int NUM_QUEUES = bmf_pkg::NUM_QUEUES_DEF,
  parameter int CW         = 5
) (
  input  wire logic [CW-1:0]                 counts [NUM_QUEUES],
  output logic      [$clog2(NUM_QUEUES)-1:0] min_idx,
  output logic      [$clog2(NUM_QUEUES)-1:0] max_idx
);

  localparam int QW  = $clog2(NUM_QUEUES);
  localparam int POW = 2 ** QW;

  logic [CW-1:0] lo_cnt [2*POW];
  logic [QW-1:0] lo_id  [2*POW];
  logic [CW-1:0] hi_cnt [2*POW];
  logic [QW-1:0] hi_id  [2*POW];

  // balanced compare tree, ties keep the left (lower) index
  always_comb begin
    lo_cnt[0] = '0;
    lo_id[0]  = '0;
    hi_cnt[0] = '0;
    hi_id[0]  = '0;
    for (int i = 0; i < POW; i++) begin
      lo_id[POW+i] = QW'(i);
      hi_id[POW+i] = QW'(i);
      if (i < NUM_QUEUES) begin
        lo_cnt[POW+i] = counts[i];
        hi_cnt[POW+i] = counts[i];
      end else begin
        lo_cnt[POW+i] = '1;
        hi_cnt[POW+i] = '0;
      end
    end
    for (int n = POW - 1; n >= 1; n--) begin
      if (lo_cnt[2*n+1] < lo_cnt[2*n]) begin
        lo_cnt[n] = lo_cnt[2*n+1];
        lo_id[n]  = lo_id[2*n+1];
      end else begin
        lo_cnt[n] = lo_cnt[2*n];
        lo_id[n]  = lo_id[2*n];
      end
      if (hi_cnt[2*n+1] > hi_cnt[2*n]) begin
        hi_cnt[n] = hi_cnt[2*n+1];
        hi_id[n]  = hi_id[2*n+1];
      end else begin
        hi_cnt[n] = hi_cnt[2*n];
        hi_id[n]  = hi_id[2*n];
      end
    end
  end

  assign min_idx = lo_id[1];
  assign max_idx = hi_id[1];

endmodule

`default_nettype wire

FILE: rtl/bmf_store.sv
`default_nettype none

module bmf_store #(
  parameter int ENTRIES = bmf_pkg::NUM_QUEUES_DEF * bmf_pkg::QUEUE_DEPTH_DEF,
  parameter int AW      = $clog2(ENTRIES)
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic                      re,
  input  wire logic [AW-1:0]             addr,
  input  wire logic [bmf_pkg::DATA_W-1:0] wdata,
  output logic      [bmf_pkg::DATA_W-1:0] rdata
);

  logic [bmf_pkg::DATA_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/balanced_multi_fifo_core.sv
// NUM_QUEUES bounded FIFOs of signed 32-bit words, QUEUE_DEPTH deep each, in one shared
// single-port store. An insert item goes to the queue with the fewest entries and a delete
// item pops the head of the queue with the most entries, ties going to the lowest index;
// an insert with every queue full answers status 1, a delete with every queue empty answers
// status 2, and neither touches the queues. One item is taken every cycle while the output
// does not stall: the item sits in an input register while a compare tree over the fill
// counts picks the queue and the store is written or read, and its result then moves into
// the output register. Each item thus passes through the input and result registers; the
// store's registered read port loads at the same edge as the result register.
// The store needs no clearing after reset; the queues start empty.
`default_nettype none

module balanced_multi_fifo_core #(
  parameter int NUM_QUEUES  = bmf_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = bmf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             mode,
  input  wire logic signed [bmf_pkg::DATA_W-1:0] value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic             [1:0]                status,
  output logic             [1:0]                queue_number,
  output logic signed      [bmf_pkg::DATA_W-1:0] data
);

  localparam int QW      = $clog2(NUM_QUEUES);
  localparam int PW      = $clog2(QUEUE_DEPTH);
  localparam int CW      = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW      = $clog2(ENTRIES);

  logic [CW-1:0] counts [NUM_QUEUES];
  logic [PW-1:0] heads  [NUM_QUEUES];
  logic [PW-1:0] tails  [NUM_QUEUES];

  logic                       valid_a;
  bmf_pkg::mode_t             mode_a;
  logic [bmf_pkg::DATA_W-1:0] value_a;

  logic                       valid_b;
  bmf_pkg::status_t           status_b;
  bmf_pkg::qnum_t             qnum_b;
  logic [bmf_pkg::DATA_W-1:0] data_b;
  logic                       from_mem_b;

  logic [QW-1:0]              min_idx;
  logic [QW-1:0]              max_idx;
  logic [QW-1:0]              sel_q;
  logic [PW-1:0]              sel_ptr;
  logic [AW-1:0]              addr;
  logic [bmf_pkg::DATA_W-1:0] rdata;

  logic advance;
  logic is_del;
  logic all_full;
  logic all_empty;
  logic do_ins;
  logic do_del;

  bmf_select #(
    .NUM_QUEUES(NUM_QUEUES),
    .CW        (CW)
  ) u_select (
    .counts (counts),
    .min_idx(min_idx),
    .max_idx(max_idx)
  );

  always_comb begin
    is_del    = (mode_a == bmf_pkg::MODE_DELETE);
    all_full  = (counts[min_idx] == CW'(QUEUE_DEPTH));
    all_empty = (counts[max_idx] == '0);
    advance   = valid_a && (!valid_b || out_ready);
    do_ins    = advance && !is_del && !all_full;
    do_del    = advance && is_del && !all_empty;
    sel_q     = is_del ? max_idx : min_idx;
    sel_ptr   = is_del ? heads[max_idx] : tails[min_idx];
    addr      = AW'(AW'(sel_q) * AW'(QUEUE_DEPTH) + AW'(sel_ptr));
  end

  assign in_ready = !valid_a || advance;

  bmf_store #(
    .ENTRIES(ENTRIES),
    .AW     (AW)
  ) u_store (
    .clk  (clk),
    .we   (do_ins),
    .re   (do_del),
    .addr (addr),
    .wdata(value_a),
    .rdata(rdata)
  );

  // queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        counts[i] <= '0;
        heads[i]  <= '0;
        tails[i]  <= '0;
      end
    end else if (do_ins) begin
      counts[min_idx] <= counts[min_idx] + CW'(1);
      tails[min_idx]  <= (tails[min_idx] == PW'(QUEUE_DEPTH - 1)) ? '0
                         : tails[min_idx] + PW'(1);
    end else if (do_del) begin
      counts[max_idx] <= counts[max_idx] - CW'(1);
      heads[max_idx]  <= (heads[max_idx] == PW'(QUEUE_DEPTH - 1)) ? '0
                         : heads[max_idx] + PW'(1);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (in_ready) begin
      valid_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mode_a  <= bmf_pkg::mode_t'(mode);
      value_a <= value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else if (advance) begin
      valid_b <= 1'b1;
    end else if (out_ready) begin
      valid_b <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      from_mem_b <= do_del;
      if (is_del && all_empty) begin
        status_b <= bmf_pkg::STATUS_EMPTY;
        qnum_b   <= '0;
        data_b   <= '0;
      end else if (!is_del && all_full) begin
        status_b <= bmf_pkg::STATUS_FULL;
        qnum_b   <= '0;
        data_b   <= '0;
      end else begin
        status_b <= bmf_pkg::STATUS_DONE;
        qnum_b   <= bmf_pkg::qnum_t'(sel_q);
        data_b   <= value_a;
      end
    end
  end

  assign out_valid    = valid_b;
  assign status       = status_b;
  assign queue_number = qnum_b;
  assign data         = from_mem_b ? rdata : data_b;

endmodule

`default_nettype wire

FILE: rtl/bmf_checker.sv
`default_nettype none

module bmf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [1:0]  queue_number,
  input wire logic [31:0] data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(queue_number)
      && $stable(data))
    else $error("result changed while stalled");

  // error results carry no queue and no word
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == bmf_pkg::STATUS_FULL || status == bmf_pkg::STATUS_EMPTY)
      |-> queue_number == 2'd0 && data == 32'd0)
    else $error("error result with nonzero fields");

  // reset leaves no result pending and the input open
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("state after reset");

endmodule

bind balanced_multi_fifo_core bmf_checker u_bmf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .queue_number(queue_number),
  .data        (data)
);

`default_nettype wire
